/* design/sw_lap_pkg.sv */
// ----------------------------------------------------------------------------
// Stopwatch package
// Shared widths, key codes and default settings for the lap stopwatch.
// ----------------------------------------------------------------------------
package sw_lap_pkg;

  localparam int DIGIT_W      = 4;
  localparam int NUM_DIGITS   = 4;
  localparam int KEY_W        = 7;
  localparam int TERM_W       = 9;
  localparam int CURSOR_OUT_W = 4;
  localparam int LAP_W        = DIGIT_W * NUM_DIGITS;

  localparam int                LAP_SLOTS_DEFAULT = 10;
  localparam logic [TERM_W-1:0] TERM_RESET        = 9'd367;
  localparam logic [DIGIT_W-1:0] DIGIT_MAX        = 4'd9;

  typedef logic [DIGIT_W-1:0] digit_t;
  typedef digit_t             digits_t [NUM_DIGITS];

  typedef enum logic [KEY_W-1:0] {
    KEY_UP    = 7'h44,
    KEY_SAVE  = 7'h46,
    KEY_CLEAR = 7'h47,
    KEY_DOWN  = 7'h4c,
    KEY_START = 7'h4e,
    KEY_STOP  = 7'h4f
  } key_code_t;

endpackage

/* design/sw_lap_if.sv */
// ----------------------------------------------------------------------------
// Stopwatch channels
// Valid/ready channels for the input events and the display results.
// ----------------------------------------------------------------------------
interface sw_lap_in_if;
  import sw_lap_pkg::*;

  logic             valid;
  logic             ready;
  logic             func;
  logic [KEY_W-1:0] key_code;

  modport source (output valid, func, key_code, input ready);
  modport sink   (input valid, func, key_code, output ready);
endinterface

interface sw_lap_out_if;
  import sw_lap_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [DIGIT_W-1:0]      digit_high;
  logic [DIGIT_W-1:0]      digit_second;
  logic [DIGIT_W-1:0]      digit_third;
  logic [DIGIT_W-1:0]      digit_low;
  logic                    is_running;
  logic                    is_reviewing;
  logic [CURSOR_OUT_W-1:0] lap_cursor;
  logic                    show_dashes;

  modport source (output valid, digit_high, digit_second, digit_third, digit_low,
                  is_running, is_reviewing, lap_cursor, show_dashes, input ready);
  modport sink   (input valid, digit_high, digit_second, digit_third, digit_low,
                  is_running, is_reviewing, lap_cursor, show_dashes, output ready);
endinterface

/* design/stopwatch_with_lap_memory_unit.sv */
// ----------------------------------------------------------------------------
// Stopwatch with lap memory
// Four-digit BCD stopwatch with prescaler, start/stop/clear keys and a
// shifting store of lap times that can be stepped through for review.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one event per beat: func = 0 is a timer tick, func = 1 a
//   key event whose key_code selects start, stop, clear, save, up or down.
//   out_ch returns exactly one beat per input beat: the four digits, the
//   running and reviewing flags, the review cursor and the dash flag.
//   cfg_wr_en/cfg_wr_data write the prescaler terminal count; write it only
//   while no event is in flight.
// Timing:
//   The whole update runs in the accepting cycle; the result appears in the
//   output register in the next cycle. One event is taken every cycle as long
//   as the output register is empty or being drained in the same cycle.
//   If the receiver stalls, the result holds and in_ch.ready drops until it
//   is taken.
// Reset:
//   Digits, prescaler, cursor and flags clear, the terminal returns to 367
//   and lap slot i holds digit (i mod 10) in every place. No clearing pass.
// ----------------------------------------------------------------------------
module stopwatch_with_lap_memory_unit #(
  parameter int LAP_SLOTS = sw_lap_pkg::LAP_SLOTS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [sw_lap_pkg::TERM_W-1:0] cfg_wr_data,
  sw_lap_in_if.sink                     in_ch,
  sw_lap_out_if.source                  out_ch
);
  import sw_lap_pkg::*;

  localparam int CW = (LAP_SLOTS > 1) ? $clog2(LAP_SLOTS) : 1;
  localparam logic [CW-1:0] CURSOR_LAST = CW'(LAP_SLOTS - 1);

  // state
  logic [TERM_W-1:0] terminal;
  logic [TERM_W-1:0] prescale;
  logic [TERM_W-1:0] prescale_next;
  digits_t           digits;
  digits_t           digits_next;
  logic [CW-1:0]     cursor;
  logic [CW-1:0]     cursor_next;
  logic              running;
  logic              running_next;
  logic              reviewing;
  logic              reviewing_next;
  logic              save_en;
  logic [LAP_W-1:0]  lap [LAP_SLOTS];
  logic [LAP_W-1:0]  counter_word;

  logic accept;
  logic out_valid;

  assign accept       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = !out_valid || out_ch.ready;
  assign counter_word = {digits[0], digits[1], digits[2], digits[3]};

  // next-state logic for one event
  always_comb begin
    logic              carry;
    logic [TERM_W-1:0] p1;
    logic [LAP_W-1:0]  word;
    logic              do_load;
    prescale_next  = prescale;
    digits_next    = digits;
    cursor_next    = cursor;
    running_next   = running;
    reviewing_next = reviewing;
    save_en        = 1'b0;
    do_load        = 1'b0;
    carry          = 1'b0;
    p1             = prescale + TERM_W'(1);
    if (!in_ch.func) begin
      if (running) begin
        if (p1 == terminal) begin
          prescale_next = '0;
          carry         = 1'b1;
        end else begin
          prescale_next = p1;
        end
        // ripple the carry from the low digit upwards; top carry is dropped
        for (int i = NUM_DIGITS - 1; i >= 0; i--) begin
          if (carry) begin
            if (digits[i] >= DIGIT_MAX) begin
              digits_next[i] = '0;
            end else begin
              digits_next[i] = digits[i] + DIGIT_W'(1);
              carry          = 1'b0;
            end
          end
        end
      end
    end else begin
      case (in_ch.key_code)
        KEY_UP, KEY_DOWN: begin
          if (!reviewing) begin
            cursor_next    = '0;
            reviewing_next = 1'b1;
            do_load        = 1'b1;
          end else if (!running) begin
            do_load = 1'b1;
            if (in_ch.key_code == KEY_UP) begin
              if (cursor < CURSOR_LAST) begin
                cursor_next = cursor + CW'(1);
              end else begin
                cursor_next = CURSOR_LAST;
              end
            end else if (cursor != '0) begin
              cursor_next = cursor - CW'(1);
            end
          end
        end
        KEY_SAVE: begin
          save_en        = 1'b1;
          reviewing_next = 1'b0;
        end
        KEY_CLEAR: begin
          for (int i = 0; i < NUM_DIGITS; i++) digits_next[i] = '0;
        end
        KEY_START: begin
          running_next = 1'b1;
          if (reviewing) begin
            for (int i = 0; i < NUM_DIGITS; i++) digits_next[i] = '0;
            reviewing_next = 1'b0;
          end
        end
        KEY_STOP: begin
          running_next   = 1'b0;
          reviewing_next = 1'b0;
        end
        default: begin
        end
      endcase
    end
    word = lap[cursor_next];
    if (do_load) begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
        digits_next[i] = word[LAP_W - 1 - i*DIGIT_W -: DIGIT_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      terminal <= TERM_RESET;
    end else if (cfg_wr_en) begin
      terminal <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prescale  <= '0;
      cursor    <= '0;
      running   <= 1'b0;
      reviewing <= 1'b0;
      for (int i = 0; i < NUM_DIGITS; i++) digits[i] <= '0;
    end else if (accept) begin
      prescale  <= prescale_next;
      cursor    <= cursor_next;
      running   <= running_next;
      reviewing <= reviewing_next;
      digits    <= digits_next;
    end
  end

  // lap store: shift towards the end on save, slot 0 takes the counter
  for (genvar g = 0; g < LAP_SLOTS; g++) begin : g_lap
    localparam logic [DIGIT_W-1:0] RST_DIGIT = DIGIT_W'(g % 10);
    always_ff @(posedge clk) begin
      if (rst) begin
        lap[g] <= {NUM_DIGITS{RST_DIGIT}};
      end else if (accept && save_en) begin
        if (g == 0) begin
          lap[g] <= counter_word;
        end else begin
          lap[g] <= lap[(g > 0) ? g - 1 : 0];
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_ch.digit_high   <= digits_next[0];
      out_ch.digit_second <= digits_next[1];
      out_ch.digit_third  <= digits_next[2];
      out_ch.digit_low    <= digits_next[3];
      out_ch.is_running   <= running_next;
      out_ch.is_reviewing <= reviewing_next;
      out_ch.lap_cursor   <= CURSOR_OUT_W'(cursor_next);
      out_ch.show_dashes  <= !running_next && (digits_next[3] == '0) && !reviewing_next;
    end
  end

  assign out_ch.valid = out_valid;

  // checks
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    cursor <= CURSOR_LAST)
    else $error("review cursor beyond last lap slot");

  a_digits_bcd: assert property (@(posedge clk) disable iff (rst)
    digits[0] <= DIGIT_MAX && digits[1] <= DIGIT_MAX &&
    digits[2] <= DIGIT_MAX && digits[3] <= DIGIT_MAX)
    else $error("counter digit left BCD range");

  a_idle_tick: assert property (@(posedge clk) disable iff (rst)
    accept && !in_ch.func && !running |=>
      $stable(prescale) && $stable(counter_word) && $stable(cursor))
    else $error("tick while stopped changed the state");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ch.ready |-> !accept)
    else $error("event taken while a result was stalled");

endmodule
